[hw/rtl/phs_pkg.sv]
// shared types and constants of the polygon half-plane split unit
`timescale 1ns / 1ps

package phs_pkg;

    localparam int COORD_BITS = 32;
    localparam int FRAC_BITS  = 16;
    localparam int SIDE_W     = 2 * COORD_BITS + 2;
    localparam int LO_W       = SIDE_W / 2;
    localparam int MULB_W     = LO_W + 1;
    localparam int PROD_W     = COORD_BITS + MULB_W;
    localparam int DIFF_W     = SIDE_W + 1;
    localparam int ACC_W      = COORD_BITS + SIDE_W + 2;
    localparam int REM_W      = ACC_W + 1;
    localparam int QUO_BITS   = COORD_BITS + 1;
    localparam int STEP_W     = 6;
    localparam int HELD_DEPTH = 3;
    localparam int HELD_IDX_W = 2;
    localparam int CFG_IDX_W  = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LINE_OFFSET  = 2'd0,
        CFG_OFFSET_SHIFT = 2'd1,
        CFG_COEF_ON_Z    = 2'd2,
        CFG_COEF_ON_Y    = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SIDE,
        ST_DECIDE,
        ST_CR_MUL,
        ST_CR_DIV,
        ST_AFTER_CROSS,
        ST_PUSH_CUR,
        ST_EMIT_HELD,
        ST_EMIT_CROSS,
        ST_EMIT_CUR,
        ST_EMIT_CLOSE,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        MS_CY_VY,
        MS_CZ_VZ,
        MS_C_PLO,
        MS_C_PHI,
        MS_P_CLO,
        MS_P_CHI
    } mul_sel_t;

    typedef enum logic [1:0] {
        ES_HELD,
        ES_CROSS,
        ES_CUR
    } emit_src_t;

    typedef struct packed {
        logic                  load_in;
        logic                  mul_en;
        mul_sel_t              mul_sel;
        logic                  acc_clr;
        logic                  acc_init_l;
        logic                  acc_en;
        logic                  latch_side;
        logic                  set_start;
        logic                  commit_last;
        logic                  edge_close;
        logic                  coord_z;
        logic                  div_init;
        logic                  div_step;
        logic                  div_store;
        logic                  held_wr;
        logic                  held_wr_cross;
        logic [HELD_IDX_W-1:0] held_idx;
        logic                  emit;
        emit_src_t             emit_src;
        logic                  run_end;
        logic                  poly_done;
    } cmd_t;

    typedef struct packed {
        logic cross_in;
        logic cross_close;
        logic fin;
        logic out_free;
    } status_t;

endpackage

[hw/rtl/phs_datapath.sv]
// datapath: registers, shared multiplier, accumulator, divider, held items, output register
`timescale 1ns / 1ps

module phs_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [phs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [phs_pkg::COORD_BITS-1:0]      cfg_wr_data,
    input  logic signed [phs_pkg::COORD_BITS-1:0] s_vert_y,
    input  logic signed [phs_pkg::COORD_BITS-1:0] s_vert_z,
    input  logic                                s_final_vertex,
    input  phs_pkg::cmd_t                       cmd,
    output phs_pkg::status_t                    status,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [phs_pkg::COORD_BITS-1:0] m_point_y,
    output logic signed [phs_pkg::COORD_BITS-1:0] m_point_z,
    output logic                                m_to_plus_part,
    output logic                                m_to_minus_part,
    output logic                                m_run_end,
    output logic                                m_polygon_done
);

    localparam int CB = phs_pkg::COORD_BITS;
    localparam int SW = phs_pkg::SIDE_W;
    localparam int LW = phs_pkg::LO_W;
    localparam int BW = phs_pkg::MULB_W;
    localparam int PW = phs_pkg::PROD_W;
    localparam int DW = phs_pkg::DIFF_W;
    localparam int AW = phs_pkg::ACC_W;
    localparam int RW = phs_pkg::REM_W;
    localparam int QB = phs_pkg::QUO_BITS;

    logic [CB-1:0] line_offset_reg, offset_shift_reg, coef_on_z_reg, coef_on_y_reg;

    logic signed [CB-1:0] cur_y_reg, cur_z_reg, last_y_reg, last_z_reg;
    logic signed [CB-1:0] start_y_reg, start_z_reg;
    logic [SW-1:0]        cur_side_reg, last_side_reg, start_side_reg;
    logic                 fin_reg;

    logic signed [PW-1:0] prod_reg;
    phs_pkg::mul_sel_t    prod_sel_reg;
    logic signed [AW-1:0] acc_reg, acc_next;

    logic [RW-1:0] rem_reg, dsh_reg;
    logic [QB-1:0] quo_reg;
    logic          neg_reg;
    logic signed [CB-1:0] cross_y_reg, cross_z_reg;

    logic signed [CB-1:0] held_y_reg [phs_pkg::HELD_DEPTH];
    logic signed [CB-1:0] held_z_reg [phs_pkg::HELD_DEPTH];
    logic                 held_plus_reg [phs_pkg::HELD_DEPTH];
    logic                 held_minus_reg [phs_pkg::HELD_DEPTH];

    logic                 m_valid_reg;
    logic signed [CB-1:0] m_point_y_reg, m_point_z_reg;
    logic m_plus_reg, m_minus_reg, m_run_end_reg, m_done_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_offset_reg  <= '0;
            offset_shift_reg <= '0;
            coef_on_z_reg    <= '0;
            coef_on_y_reg    <= '0;
        end else if (cfg_wr_en) begin
            case (phs_pkg::cfg_idx_t'(cfg_index))
                phs_pkg::CFG_LINE_OFFSET:  line_offset_reg  <= cfg_wr_data;
                phs_pkg::CFG_OFFSET_SHIFT: offset_shift_reg <= cfg_wr_data;
                phs_pkg::CFG_COEF_ON_Z:    coef_on_z_reg    <= cfg_wr_data;
                phs_pkg::CFG_COEF_ON_Y:    coef_on_y_reg    <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // edge operands: previous end p, current end c
    logic signed [CB-1:0] p_coord, c_coord;
    logic [SW-1:0]        p_side, c_side;
    always_comb begin
        if (cmd.edge_close) begin
            p_side  = cur_side_reg;
            c_side  = start_side_reg;
            p_coord = cmd.coord_z ? cur_z_reg : cur_y_reg;
            c_coord = cmd.coord_z ? start_z_reg : start_y_reg;
        end else begin
            p_side  = last_side_reg;
            c_side  = cur_side_reg;
            p_coord = cmd.coord_z ? last_z_reg : last_y_reg;
            c_coord = cmd.coord_z ? cur_z_reg : cur_y_reg;
        end
    end

    // shared multiplier operands
    logic signed [CB-1:0] mul_a;
    logic signed [BW-1:0] mul_b;
    always_comb begin
        case (cmd.mul_sel)
            phs_pkg::MS_CY_VY: begin
                mul_a = cur_y_reg;
                mul_b = {{(BW-CB){coef_on_y_reg[CB-1]}}, coef_on_y_reg};
            end
            phs_pkg::MS_CZ_VZ: begin
                mul_a = cur_z_reg;
                mul_b = {{(BW-CB){coef_on_z_reg[CB-1]}}, coef_on_z_reg};
            end
            phs_pkg::MS_C_PLO: begin
                mul_a = c_coord;
                mul_b = {1'b0, p_side[LW-1:0]};
            end
            phs_pkg::MS_C_PHI: begin
                mul_a = c_coord;
                mul_b = {p_side[SW-1], p_side[SW-1:LW]};
            end
            phs_pkg::MS_P_CLO: begin
                mul_a = p_coord;
                mul_b = {1'b0, c_side[LW-1:0]};
            end
            phs_pkg::MS_P_CHI: begin
                mul_a = p_coord;
                mul_b = {c_side[SW-1], c_side[SW-1:LW]};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // accumulator: side value or crossing numerator
    logic signed [CB:0]   l_diff;
    logic signed [AW-1:0] term;
    always_comb begin
        l_diff = {line_offset_reg[CB-1], line_offset_reg}
               - {offset_shift_reg[CB-1], offset_shift_reg};
        term = {{(AW-PW){prod_reg[PW-1]}}, prod_reg};
        if (prod_sel_reg == phs_pkg::MS_C_PHI || prod_sel_reg == phs_pkg::MS_P_CHI) begin
            term = term <<< LW;
        end
        acc_next = acc_reg;
        if (cmd.acc_clr) begin
            acc_next = '0;
        end else if (cmd.acc_init_l) begin
            acc_next = {{(AW-CB-1){l_diff[CB]}}, l_diff} <<< phs_pkg::FRAC_BITS;
        end else if (cmd.acc_en) begin
            if (prod_sel_reg == phs_pkg::MS_P_CLO || prod_sel_reg == phs_pkg::MS_P_CHI) begin
                acc_next = acc_reg - term;
            end else begin
                acc_next = acc_reg + term;
            end
        end
    end

    // divider operands
    logic signed [DW-1:0] diff;
    logic [DW-1:0]        abs_d;
    logic [AW-1:0]        abs_n;
    logic [RW-1:0]        rem_sub;
    logic [CB-1:0]        quo_signed;
    always_comb begin
        diff  = {p_side[SW-1], p_side} - {c_side[SW-1], c_side};
        abs_d = diff[DW-1] ? DW'(-diff) : DW'(diff);
        abs_n = acc_reg[AW-1] ? AW'(-acc_reg) : AW'(acc_reg);
        rem_sub = rem_reg - dsh_reg;
        quo_signed = neg_reg ? (~quo_reg[CB-1:0] + CB'(1)) : quo_reg[CB-1:0];
    end

    logic cur_neg, cur_zero;
    assign cur_neg  = cur_side_reg[SW-1];
    assign cur_zero = (cur_side_reg == '0);

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            cur_y_reg <= s_vert_y;
            cur_z_reg <= s_vert_z;
            fin_reg   <= s_final_vertex;
        end
        if (cmd.mul_en) begin
            prod_reg     <= mul_a * mul_b;
            prod_sel_reg <= cmd.mul_sel;
        end
        acc_reg <= acc_next;
        if (cmd.latch_side) begin
            cur_side_reg <= acc_reg[SW-1:0];
        end
        if (cmd.set_start) begin
            start_y_reg    <= cur_y_reg;
            start_z_reg    <= cur_z_reg;
            start_side_reg <= cur_side_reg;
        end
        if (cmd.commit_last) begin
            last_y_reg    <= cur_y_reg;
            last_z_reg    <= cur_z_reg;
            last_side_reg <= cur_side_reg;
        end
        if (cmd.div_init) begin
            // round to nearest: (2|n| + |d|) / (2|d|)
            rem_reg <= {abs_n, 1'b0} + {{(RW-DW){1'b0}}, abs_d};
            dsh_reg <= {{(RW-DW-QB){1'b0}}, abs_d, {QB{1'b0}}};
            quo_reg <= '0;
            neg_reg <= acc_reg[AW-1] ^ diff[DW-1];
        end else if (cmd.div_step) begin
            if (rem_reg >= dsh_reg) begin
                rem_reg <= rem_sub;
                quo_reg <= {quo_reg[QB-2:0], 1'b1};
            end else begin
                quo_reg <= {quo_reg[QB-2:0], 1'b0};
            end
            dsh_reg <= dsh_reg >> 1;
        end
        if (cmd.div_store) begin
            if (cmd.coord_z) begin
                cross_z_reg <= quo_signed;
            end else begin
                cross_y_reg <= quo_signed;
            end
        end
        if (cmd.held_wr) begin
            if (cmd.held_wr_cross) begin
                held_y_reg[cmd.held_idx]     <= cross_y_reg;
                held_z_reg[cmd.held_idx]     <= cross_z_reg;
                held_plus_reg[cmd.held_idx]  <= 1'b1;
                held_minus_reg[cmd.held_idx] <= 1'b1;
            end else begin
                held_y_reg[cmd.held_idx]     <= cur_y_reg;
                held_z_reg[cmd.held_idx]     <= cur_z_reg;
                held_plus_reg[cmd.held_idx]  <= !cur_neg;
                held_minus_reg[cmd.held_idx] <= cur_neg | cur_zero;
            end
        end
        if (cmd.emit) begin
            m_run_end_reg <= cmd.run_end;
            m_done_reg    <= cmd.poly_done;
            case (cmd.emit_src)
                phs_pkg::ES_HELD: begin
                    m_point_y_reg <= held_y_reg[cmd.held_idx];
                    m_point_z_reg <= held_z_reg[cmd.held_idx];
                    m_plus_reg    <= held_plus_reg[cmd.held_idx];
                    m_minus_reg   <= held_minus_reg[cmd.held_idx];
                end
                phs_pkg::ES_CROSS: begin
                    m_point_y_reg <= cross_y_reg;
                    m_point_z_reg <= cross_z_reg;
                    m_plus_reg    <= 1'b1;
                    m_minus_reg   <= 1'b1;
                end
                default: begin
                    m_point_y_reg <= cur_y_reg;
                    m_point_z_reg <= cur_z_reg;
                    m_plus_reg    <= !cur_neg;
                    m_minus_reg   <= cur_neg | cur_zero;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // strict sign change: both nonzero, signs differ
    assign status.cross_in = (last_side_reg != '0) && !cur_zero
                           && (last_side_reg[SW-1] != cur_neg);
    assign status.cross_close = (start_side_reg != '0) && !cur_zero
                              && (start_side_reg[SW-1] != cur_neg);
    assign status.fin      = fin_reg;
    assign status.out_free = !m_valid_reg || m_ready;

    assign m_valid         = m_valid_reg;
    assign m_point_y       = m_point_y_reg;
    assign m_point_z       = m_point_z_reg;
    assign m_to_plus_part  = m_plus_reg;
    assign m_to_minus_part = m_minus_reg;
    assign m_run_end       = m_run_end_reg;
    assign m_polygon_done  = m_done_reg;

endmodule

[hw/rtl/phs_ctrl.sv]
// controller: sequences side value, crossing solves, held items and emission
`timescale 1ns / 1ps

module phs_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  phs_pkg::status_t  status,
    output phs_pkg::cmd_t     cmd
);

    localparam int SW_ = phs_pkg::STEP_W;
    localparam logic [SW_-1:0] DIV_LAST = SW_'(phs_pkg::QUO_BITS + 1);

    phs_pkg::state_t state_reg, state_next;
    logic [SW_-1:0]  step_reg, step_next;
    logic [phs_pkg::HELD_IDX_W-1:0] held_n_reg, held_n_next, idx_reg, idx_next;
    logic [1:0] seen_reg, seen_next;
    logic crossed_reg, crossed_next, edge_reg, edge_next, coordz_reg, coordz_next;
    logic close_needed;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= phs_pkg::ST_IDLE;
            step_reg    <= '0;
            held_n_reg  <= '0;
            idx_reg     <= '0;
            seen_reg    <= '0;
            crossed_reg <= 1'b0;
            edge_reg    <= 1'b0;
            coordz_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            held_n_reg  <= held_n_next;
            idx_reg     <= idx_next;
            seen_reg    <= seen_next;
            crossed_reg <= crossed_next;
            edge_reg    <= edge_next;
            coordz_reg  <= coordz_next;
        end
    end

    assign close_needed = status.fin && status.cross_close;

    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        held_n_next  = held_n_reg;
        idx_next     = idx_reg;
        seen_next    = seen_reg;
        crossed_next = crossed_reg;
        edge_next    = edge_reg;
        coordz_next  = coordz_reg;
        cmd          = '0;
        cmd.edge_close = edge_reg;
        cmd.coord_z    = coordz_reg;
        s_ready      = 1'b0;

        case (state_reg)
            phs_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in    = 1'b1;
                    cmd.acc_init_l = 1'b1;
                    step_next      = '0;
                    state_next     = phs_pkg::ST_SIDE;
                end
            end
            phs_pkg::ST_SIDE: begin
                step_next = step_reg + SW_'(1);
                case (step_reg)
                    SW_'(0): begin
                        cmd.mul_en  = 1'b1;
                        cmd.mul_sel = phs_pkg::MS_CY_VY;
                    end
                    SW_'(1): begin
                        cmd.mul_en  = 1'b1;
                        cmd.mul_sel = phs_pkg::MS_CZ_VZ;
                        cmd.acc_en  = 1'b1;
                    end
                    SW_'(2): cmd.acc_en = 1'b1;
                    default: begin
                        cmd.latch_side = 1'b1;
                        state_next     = phs_pkg::ST_DECIDE;
                    end
                endcase
            end
            phs_pkg::ST_DECIDE: begin
                cmd.set_start = (seen_reg == 2'd0);
                if (seen_reg < 2'd2 && status.fin) begin
                    // short polygon: drop everything
                    seen_next   = '0;
                    held_n_next = '0;
                    state_next  = phs_pkg::ST_FINISH;
                end else if (seen_reg != 2'd0 && status.cross_in) begin
                    crossed_next = 1'b1;
                    edge_next    = 1'b0;
                    coordz_next  = 1'b0;
                    step_next    = '0;
                    state_next   = phs_pkg::ST_CR_MUL;
                end else begin
                    crossed_next = 1'b0;
                    state_next   = phs_pkg::ST_AFTER_CROSS;
                end
            end
            phs_pkg::ST_CR_MUL: begin
                // numerator c*ps - p*cs, side values in two halves
                step_next = step_reg + SW_'(1);
                case (step_reg)
                    SW_'(0): begin
                        cmd.acc_clr = 1'b1;
                        cmd.mul_en  = 1'b1;
                        cmd.mul_sel = phs_pkg::MS_C_PLO;
                    end
                    SW_'(1): begin
                        cmd.mul_en  = 1'b1;
                        cmd.mul_sel = phs_pkg::MS_C_PHI;
                        cmd.acc_en  = 1'b1;
                    end
                    SW_'(2): begin
                        cmd.mul_en  = 1'b1;
                        cmd.mul_sel = phs_pkg::MS_P_CLO;
                        cmd.acc_en  = 1'b1;
                    end
                    SW_'(3): begin
                        cmd.mul_en  = 1'b1;
                        cmd.mul_sel = phs_pkg::MS_P_CHI;
                        cmd.acc_en  = 1'b1;
                    end
                    default: begin
                        cmd.acc_en = 1'b1;
                        step_next  = '0;
                        state_next = phs_pkg::ST_CR_DIV;
                    end
                endcase
            end
            phs_pkg::ST_CR_DIV: begin
                step_next = step_reg + SW_'(1);
                if (step_reg == '0) begin
                    cmd.div_init = 1'b1;
                end else if (step_reg != DIV_LAST) begin
                    cmd.div_step = 1'b1;
                end else begin
                    cmd.div_store = 1'b1;
                    step_next     = '0;
                    if (!coordz_reg) begin
                        coordz_next = 1'b1;
                        state_next  = phs_pkg::ST_CR_MUL;
                    end else if (edge_reg) begin
                        state_next = phs_pkg::ST_EMIT_CLOSE;
                    end else begin
                        state_next = phs_pkg::ST_AFTER_CROSS;
                    end
                end
            end
            phs_pkg::ST_AFTER_CROSS: begin
                if (seen_reg < 2'd2) begin
                    if (crossed_reg) begin
                        cmd.held_wr       = 1'b1;
                        cmd.held_wr_cross = 1'b1;
                        cmd.held_idx      = held_n_reg;
                        held_n_next       = held_n_reg + 2'd1;
                    end
                    state_next = phs_pkg::ST_PUSH_CUR;
                end else begin
                    idx_next   = '0;
                    state_next = phs_pkg::ST_EMIT_HELD;
                end
            end
            phs_pkg::ST_PUSH_CUR: begin
                cmd.held_wr  = 1'b1;
                cmd.held_idx = held_n_reg;
                held_n_next  = held_n_reg + 2'd1;
                seen_next    = seen_reg + 2'd1;
                state_next   = phs_pkg::ST_FINISH;
            end
            phs_pkg::ST_EMIT_HELD: begin
                cmd.held_idx = idx_reg;
                if (idx_reg == held_n_reg) begin
                    state_next = crossed_reg ? phs_pkg::ST_EMIT_CROSS : phs_pkg::ST_EMIT_CUR;
                end else if (status.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.emit_src = phs_pkg::ES_HELD;
                    idx_next     = idx_reg + 2'd1;
                end
            end
            phs_pkg::ST_EMIT_CROSS: begin
                if (status.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.emit_src = phs_pkg::ES_CROSS;
                    state_next   = phs_pkg::ST_EMIT_CUR;
                end
            end
            phs_pkg::ST_EMIT_CUR: begin
                if (status.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_src  = phs_pkg::ES_CUR;
                    cmd.run_end   = !close_needed;
                    cmd.poly_done = status.fin && !close_needed;
                    if (close_needed) begin
                        // closing edge back to the first vertex
                        edge_next   = 1'b1;
                        coordz_next = 1'b0;
                        step_next   = '0;
                        state_next  = phs_pkg::ST_CR_MUL;
                    end else begin
                        held_n_next = '0;
                        seen_next   = status.fin ? 2'd0 : 2'd3;
                        state_next  = phs_pkg::ST_FINISH;
                    end
                end
            end
            phs_pkg::ST_EMIT_CLOSE: begin
                if (status.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_src  = phs_pkg::ES_CROSS;
                    cmd.run_end   = 1'b1;
                    cmd.poly_done = 1'b1;
                    held_n_next   = '0;
                    seen_next     = 2'd0;
                    state_next    = phs_pkg::ST_FINISH;
                end
            end
            phs_pkg::ST_FINISH: begin
                cmd.commit_last = 1'b1;
                edge_next       = 1'b0;
                state_next      = phs_pkg::ST_IDLE;
            end
            default: state_next = phs_pkg::ST_IDLE;
        endcase
    end

endmodule

[hw/rtl/polygon_halfplane_split_unit.sv]
// top level of the polygon half-plane split unit
`timescale 1ns / 1ps

// vertices enter on the s_ channel (valid/ready), one item per vertex, with
// s_final_vertex on the last vertex of a polygon. points leave on the m_
// channel, each tagged with the part(s) it joins, run_end on the last point
// caused by a vertex and polygon_done on the last point of the polygon.
// the line is set through cfg_wr_en/cfg_index/cfg_wr_data; the user must
// write it only while idle, the block does not enforce this. each edge
// crossing runs the shared multiplier and the one-bit-per-cycle divider
// once for y and once for z; worst case is two crossings and six points.
// the first two vertices give no points; their points are held and sent
// ahead of the third vertex's points. a polygon ending before a third
// vertex gives nothing. a stalled m_ready holds the output register and the
// sequencer waits; the next vertex is taken once the finish state has
// returned the sequencer to idle after the last point is loaded into the
// output register. after reset the line is all zero and no polygon is
// open.
module polygon_halfplane_split_unit (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [phs_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [phs_pkg::COORD_BITS-1:0]        cfg_wr_data,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [phs_pkg::COORD_BITS-1:0] s_vert_y,
    input  logic signed [phs_pkg::COORD_BITS-1:0] s_vert_z,
    input  logic                                  s_final_vertex,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [phs_pkg::COORD_BITS-1:0] m_point_y,
    output logic signed [phs_pkg::COORD_BITS-1:0] m_point_z,
    output logic                                  m_to_plus_part,
    output logic                                  m_to_minus_part,
    output logic                                  m_run_end,
    output logic                                  m_polygon_done
);

    phs_pkg::cmd_t    cmd;
    phs_pkg::status_t status;

    phs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    phs_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data),
        .s_vert_y        (s_vert_y),
        .s_vert_z        (s_vert_z),
        .s_final_vertex  (s_final_vertex),
        .cmd             (cmd),
        .status          (status),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_point_y       (m_point_y),
        .m_point_z       (m_point_z),
        .m_to_plus_part  (m_to_plus_part),
        .m_to_minus_part (m_to_minus_part),
        .m_run_end       (m_run_end),
        .m_polygon_done  (m_polygon_done)
    );

    // a point is only loaded into a free output register
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> status.out_free)
        else $error("point loaded over a waiting item");

    // one vertex at a time
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second vertex taken while busy");

    // polygon end is always the last point of its vertex
    a_done_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_polygon_done |-> m_run_end)
        else $error("polygon_done without run_end");

endmodule
